>>> rtl/fsrl_pkg.sv
// ----------------------------------------------------------------------------
// Free-space turn-rate law package
// Shared widths, constants, channel geometry and the transaction side-band.
// ----------------------------------------------------------------------------
package fsrl_pkg;

    // Fixed-point format of every fractional quantity.
    localparam int FRAC_BITS = 12;

    // Field widths.
    localparam int OFFSET_W = 16;
    localparam int SPEED_W  = 13;
    localparam int RATE_W   = 12;
    localparam int H_W      = 13;
    localparam int MODE_W   = 2;

    // Stream widths, padded to whole bytes.
    localparam int IN_BITS  = 4 * OFFSET_W + 4;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = RATE_W + 1 + MODE_W + H_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Lane arithmetic widths.
    localparam int DIST_W   = 4;
    localparam int K_W      = 18;
    localparam int MAG_W    = 16;
    localparam int PROD_W   = MAG_W + K_W;
    localparam int SQ_W     = 32;
    localparam int NUM_W    = PROD_W + FRAC_BITS + 1;
    localparam int DEN_W    = 35;
    localparam int QUO_W    = 16;
    localparam int TRY_W    = NUM_W + QUO_W;
    localparam int LRATE_W  = QUO_W;

    // Lane pipeline: one product stage plus one divider stage per quotient bit
    // plus the stage that forms numerator and denominator.
    localparam int LANE_LAT = QUO_W + 2;
    localparam int MERGE_LAT = 2;
    localparam int PIPE_LAT = LANE_LAT + MERGE_LAT;

    // Merge arithmetic.
    localparam int SUM_W    = 20;
    localparam int RECIP_SH = 24;
    localparam int RECIP5   = ((1 << RECIP_SH) + 4) / 5;
    localparam int RECIP_W  = 22;

    // Output constants.
    localparam int RATE_LIMIT  = ((3 << FRAC_BITS) + 5) / 10;
    localparam int H_MIDFAR    = ((13 << FRAC_BITS) + 50) / 100;
    localparam int H_NEARMID   = ((2 << FRAC_BITS) + 5) / 10;
    localparam int H_NEARCLOSE = ((29 << FRAC_BITS) + 50) / 100;
    localparam int H_OBSTACLE  = -(1 << FRAC_BITS);
    localparam int SPEED_RESET = ((18 << FRAC_BITS) + 50) / 100;

    // Channel selectors.
    typedef enum logic [1:0] {
        CH_NEAR  = 2'd0,
        CH_MID   = 2'd1,
        CH_FAR   = 2'd2,
        CH_CLOSE = 2'd3
    } chan_t;

    // Blend modes.
    typedef enum logic [MODE_W-1:0] {
        MODE_OBSTACLE  = 2'd0,
        MODE_NEARCLOSE = 2'd1,
        MODE_NEARMID   = 2'd2,
        MODE_MIDFAR    = 2'd3
    } mode_t;

    // Side-band that travels beside the lanes.
    typedef struct packed {
        mode_t mode;
        logic  ok;
    } meta_t;

    // Distance of a row as a fraction dd/dn metres.
    function automatic logic [DIST_W-1:0] chan_dd(input chan_t ch);
        logic [DIST_W-1:0] r;
        case (ch)
            CH_NEAR:  r = 4'd1;
            CH_MID:   r = 4'd1;
            CH_FAR:   r = 4'd13;
            CH_CLOSE: r = 4'd9;
            default:  r = 4'd1;
        endcase
        return r;
    endfunction

    function automatic logic [DIST_W-1:0] chan_dn(input chan_t ch);
        logic [DIST_W-1:0] r;
        case (ch)
            CH_NEAR:  r = 4'd1;
            CH_MID:   r = 4'd2;
            CH_FAR:   r = 4'd4;
            CH_CLOSE: r = 4'd10;
            default:  r = 4'd1;
        endcase
        return r;
    endfunction

    // Fusion weight reported for each mode.
    function automatic logic [H_W-1:0] mode_weight(input mode_t m);
        logic [H_W-1:0] r;
        case (m)
            MODE_OBSTACLE:  r = H_W'(H_OBSTACLE);
            MODE_NEARCLOSE: r = H_W'(H_NEARCLOSE);
            MODE_NEARMID:   r = H_W'(H_NEARMID);
            MODE_MIDFAR:    r = H_W'(H_MIDFAR);
            default:        r = H_W'(H_OBSTACLE);
        endcase
        return r;
    endfunction

endpackage

>>> rtl/fsrl_lane.sv
// ----------------------------------------------------------------------------
// Channel rate lane
// Computes round(f*(dd + v*dn)/(dd*(1 + f*f))) in Q format through a product
// stage and a restoring divider that settles one quotient bit per stage.
// ----------------------------------------------------------------------------
module fsrl_lane (
    input  logic                                clk,
    input  logic                                adv,
    input  fsrl_pkg::chan_t                     chan,
    input  logic [fsrl_pkg::SPEED_W-1:0]        base_speed,
    input  logic signed [fsrl_pkg::OFFSET_W-1:0] offset,
    output logic signed [fsrl_pkg::LRATE_W-1:0] rate
);

    localparam int STEPS = fsrl_pkg::QUO_W;

    logic [fsrl_pkg::MAG_W-1:0]  mag;
    logic [fsrl_pkg::K_W-1:0]    kval;
    logic [fsrl_pkg::PROD_W-1:0] prod_reg;
    logic [fsrl_pkg::SQ_W-1:0]   sq_reg;
    logic                        neg_a_reg;
    logic [fsrl_pkg::DIST_W-1:0] dd_a_reg;
    logic [fsrl_pkg::SQ_W-1:0]   den_base;
    logic [fsrl_pkg::DEN_W-1:0]  den_next;
    logic [fsrl_pkg::NUM_W-1:0]  num_next;

    logic [fsrl_pkg::NUM_W-1:0]  rem_reg [0:STEPS];
    logic [fsrl_pkg::DEN_W-1:0]  den_reg [0:STEPS];
    logic [fsrl_pkg::QUO_W-1:0]  quo_reg [0:STEPS];
    logic                        neg_reg [0:STEPS];

    logic [fsrl_pkg::TRY_W-1:0]  trial   [0:STEPS-1];
    logic                        fits    [0:STEPS-1];

    // Magnitude of the feature and the numerator factor 2^F*dd + v*dn.
    always_comb
    begin
        mag  = offset[fsrl_pkg::OFFSET_W-1] ? fsrl_pkg::MAG_W'(-offset)
                                            : fsrl_pkg::MAG_W'(offset);
        kval = fsrl_pkg::K_W'({fsrl_pkg::chan_dd(chan), {fsrl_pkg::FRAC_BITS{1'b0}}})
             + fsrl_pkg::K_W'(base_speed * fsrl_pkg::chan_dn(chan));
    end

    // Product stage.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= fsrl_pkg::PROD_W'(mag * kval);
            sq_reg    <= fsrl_pkg::SQ_W'(mag * mag);
            neg_a_reg <= offset[fsrl_pkg::OFFSET_W-1];
            dd_a_reg  <= fsrl_pkg::chan_dd(chan);
        end
    end

    // Numerator with the rounding half of the denominator folded in.
    always_comb
    begin
        den_base = fsrl_pkg::SQ_W'(1 << (2 * fsrl_pkg::FRAC_BITS)) + sq_reg;
        den_next = fsrl_pkg::DEN_W'(dd_a_reg * den_base);
        num_next = fsrl_pkg::NUM_W'({prod_reg, {fsrl_pkg::FRAC_BITS{1'b0}}})
                 + fsrl_pkg::NUM_W'(den_next >> 1);
    end

    // Trial subtraction for each divider stage, most significant bit first.
    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            trial[k] = fsrl_pkg::TRY_W'(rem_reg[k])
                     - (fsrl_pkg::TRY_W'(den_reg[k]) << (STEPS - 1 - k));
            fits[k]  = !trial[k][fsrl_pkg::TRY_W-1];
        end
    end

    // Divider pipeline.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= num_next;
            den_reg[0] <= den_next;
            quo_reg[0] <= '0;
            neg_reg[0] <= neg_a_reg;
            for (int k = 0; k < STEPS; k++)
            begin
                rem_reg[k+1] <= fits[k] ? fsrl_pkg::NUM_W'(trial[k]) : rem_reg[k];
                den_reg[k+1] <= den_reg[k];
                quo_reg[k+1] <= quo_reg[k] | (fsrl_pkg::QUO_W'(fits[k]) << (STEPS - 1 - k));
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    // Restore the sign of the feature.
    assign rate = neg_reg[STEPS] ? -$signed(quo_reg[STEPS]) : $signed(quo_reg[STEPS]);

endmodule

>>> rtl/fsrl_merge.sv
// ----------------------------------------------------------------------------
// Lane merge
// Blends two channel rates by mode, rounds the quotient, saturates to the
// rate limit, forces the rate to zero when it is not valid and forms the result fields.
// ----------------------------------------------------------------------------
module fsrl_merge (
    input  logic                                 clk,
    input  logic                                 adv,
    input  fsrl_pkg::meta_t                      meta,
    input  logic signed [fsrl_pkg::LRATE_W-1:0]  near_rate,
    input  logic signed [fsrl_pkg::LRATE_W-1:0]  mid_rate,
    input  logic signed [fsrl_pkg::LRATE_W-1:0]  far_rate,
    input  logic signed [fsrl_pkg::LRATE_W-1:0]  close_rate,
    output logic signed [fsrl_pkg::RATE_W-1:0]   turn_rate,
    output logic                                 rate_valid,
    output fsrl_pkg::mode_t                      mode,
    output logic signed [fsrl_pkg::H_W-1:0]      fusion_weight
);

    localparam int SW = fsrl_pkg::SUM_W;

    logic signed [SW-1:0]          blend;
    logic                          div5;
    logic [SW-1:0]                 bmag;
    logic [SW-1:0]                 mag_reg;
    logic                          neg_reg;
    logic                          div5_reg;
    fsrl_pkg::meta_t               meta_reg;
    logic [SW+fsrl_pkg::RECIP_W-1:0] prod;
    logic [SW-1:0]                 quo;
    logic [SW-1:0]                 sat;
    logic signed [fsrl_pkg::RATE_W-1:0] rate_next;
    logic signed [fsrl_pkg::RATE_W-1:0] rate_reg;
    logic                          ok_reg;
    fsrl_pkg::mode_t               mode_reg;

    // Weighted sum of the two rows that the mode selects.
    always_comb
    begin
        case (meta.mode)
            fsrl_pkg::MODE_NEARCLOSE:
            begin
                blend = SW'(2 * SW'(close_rate)) + SW'(3 * SW'(near_rate));
                div5  = 1'b1;
            end
            fsrl_pkg::MODE_NEARMID:
            begin
                blend = SW'(mid_rate) + SW'(near_rate);
                div5  = 1'b0;
            end
            fsrl_pkg::MODE_MIDFAR:
            begin
                blend = SW'(3 * SW'(mid_rate)) + SW'(2 * SW'(far_rate));
                div5  = 1'b1;
            end
            default:
            begin
                blend = '0;
                div5  = 1'b0;
            end
        endcase
        // Add half the divisor so the quotient rounds ties away from zero.
        bmag = (blend[SW-1] ? SW'(-blend) : SW'(blend)) + (div5 ? SW'(2) : SW'(1));
    end

    // Blend stage.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg  <= bmag;
            neg_reg  <= blend[SW-1];
            div5_reg <= div5;
            meta_reg <= meta;
        end
    end

    // Divide by five through a reciprocal, or by two through a shift, then clamp.
    always_comb
    begin
        prod = (SW + fsrl_pkg::RECIP_W)'(mag_reg)
             * (SW + fsrl_pkg::RECIP_W)'(fsrl_pkg::RECIP5);
        quo  = div5_reg ? SW'(prod >> fsrl_pkg::RECIP_SH) : (mag_reg >> 1);
        sat  = (quo > SW'(fsrl_pkg::RATE_LIMIT)) ? SW'(fsrl_pkg::RATE_LIMIT) : quo;
        if (!meta_reg.ok)
            rate_next = '0;
        else if (neg_reg)
            rate_next = -$signed(fsrl_pkg::RATE_W'(sat));
        else
            rate_next = $signed(fsrl_pkg::RATE_W'(sat));
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rate_reg <= rate_next;
            ok_reg   <= meta_reg.ok;
            mode_reg <= meta_reg.mode;
        end
    end

    assign turn_rate     = rate_reg;
    assign rate_valid    = ok_reg;
    assign mode          = mode_reg;
    assign fusion_weight = $signed(fsrl_pkg::mode_weight(mode_reg));

endmodule

>>> rtl/free_space_turn_rate_law_core.sv
// ----------------------------------------------------------------------------
// Free-space turn-rate law core
// Throughput is one transaction per cycle; the 16-stage divider in each lane
// and the two merge stages form one pipeline that advances as a whole.
// The pipeline stalls only while a result waits at the output.
// Reset clears all pipeline valid bits and loads base_speed with 0.18.
// ----------------------------------------------------------------------------
module free_space_turn_rate_law_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration: base_speed.
    input  logic                            cfg_wr_en,
    input  logic [fsrl_pkg::SPEED_W-1:0]    cfg_wr_data,
    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // near_offset, mid_offset, far_offset, close_offset, near_valid,
    // mid_valid, far_valid, close_valid, zero padding
    input  logic [fsrl_pkg::IN_W-1:0]       s_axis_tdata,
    // Output stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // turn_rate, rate_valid, mode, fusion_weight, zero padding
    output logic [fsrl_pkg::OUT_W-1:0]      m_axis_tdata
);

    localparam int OW = fsrl_pkg::OFFSET_W;
    localparam int LL = fsrl_pkg::LANE_LAT;
    localparam int PL = fsrl_pkg::PIPE_LAT;

    logic [fsrl_pkg::SPEED_W-1:0]  speed_reg;
    logic [PL-1:0]                 vld_reg;
    logic                          adv;
    logic                          near_valid;
    logic                          mid_valid;
    logic                          far_valid;
    logic                          close_valid;
    fsrl_pkg::meta_t               meta_in;
    fsrl_pkg::meta_t               meta_reg [0:LL-1];
    logic signed [fsrl_pkg::LRATE_W-1:0] lane_rate [0:3];
    logic signed [fsrl_pkg::RATE_W-1:0]  turn_rate;
    logic                          rate_valid;
    fsrl_pkg::mode_t               mode;
    logic signed [fsrl_pkg::H_W-1:0] fusion_weight;

    // Base speed register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            speed_reg <= fsrl_pkg::SPEED_W'(fsrl_pkg::SPEED_RESET);
        else if (cfg_wr_en)
            speed_reg <= cfg_wr_data;
    end

    // The pipeline moves whenever the output stage is free or being drained.
    assign adv           = !vld_reg[PL-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[PL-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[PL-2:0], s_axis_tvalid};
    end

    // Mode decision by row priority.
    assign near_valid  = s_axis_tdata[4*OW];
    assign mid_valid   = s_axis_tdata[4*OW+1];
    assign far_valid   = s_axis_tdata[4*OW+2];
    assign close_valid = s_axis_tdata[4*OW+3];

    always_comb
    begin
        if (!near_valid)
        begin
            meta_in.mode = fsrl_pkg::MODE_OBSTACLE;
            meta_in.ok   = 1'b0;
        end
        else if (!mid_valid)
        begin
            meta_in.mode = fsrl_pkg::MODE_NEARCLOSE;
            meta_in.ok   = close_valid;
        end
        else if (!far_valid)
        begin
            meta_in.mode = fsrl_pkg::MODE_NEARMID;
            meta_in.ok   = 1'b1;
        end
        else
        begin
            meta_in.mode = fsrl_pkg::MODE_MIDFAR;
            meta_in.ok   = 1'b1;
        end
    end

    // Side-band delay matching the lanes.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            meta_reg[0] <= meta_in;
            for (int k = 1; k < LL; k++)
                meta_reg[k] <= meta_reg[k-1];
        end
    end

    // One lane per look-ahead row.
    fsrl_lane u_lane_near (
        .clk        (clk),
        .adv        (adv),
        .chan       (fsrl_pkg::CH_NEAR),
        .base_speed (speed_reg),
        .offset     ($signed(s_axis_tdata[OW-1:0])),
        .rate       (lane_rate[0])
    );

    fsrl_lane u_lane_mid (
        .clk        (clk),
        .adv        (adv),
        .chan       (fsrl_pkg::CH_MID),
        .base_speed (speed_reg),
        .offset     ($signed(s_axis_tdata[2*OW-1:OW])),
        .rate       (lane_rate[1])
    );

    fsrl_lane u_lane_far (
        .clk        (clk),
        .adv        (adv),
        .chan       (fsrl_pkg::CH_FAR),
        .base_speed (speed_reg),
        .offset     ($signed(s_axis_tdata[3*OW-1:2*OW])),
        .rate       (lane_rate[2])
    );

    fsrl_lane u_lane_close (
        .clk        (clk),
        .adv        (adv),
        .chan       (fsrl_pkg::CH_CLOSE),
        .base_speed (speed_reg),
        .offset     ($signed(s_axis_tdata[4*OW-1:3*OW])),
        .rate       (lane_rate[3])
    );

    // Blend, round and saturate.
    fsrl_merge u_merge (
        .clk           (clk),
        .adv           (adv),
        .meta          (meta_reg[LL-1]),
        .near_rate     (lane_rate[0]),
        .mid_rate      (lane_rate[1]),
        .far_rate      (lane_rate[2]),
        .close_rate    (lane_rate[3]),
        .turn_rate     (turn_rate),
        .rate_valid    (rate_valid),
        .mode          (mode),
        .fusion_weight (fusion_weight)
    );

    // Pack the result transaction.
    assign m_axis_tdata = fsrl_pkg::OUT_W'({fusion_weight, mode, rate_valid, turn_rate});

endmodule

>>> rtl/fsrl_checker.sv
// ----------------------------------------------------------------------------
// Free-space turn-rate law port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module fsrl_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [fsrl_pkg::SPEED_W-1:0]    cfg_wr_data,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [fsrl_pkg::IN_W-1:0]       s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [fsrl_pkg::OUT_W-1:0]      m_axis_tdata
);

    localparam int RW = fsrl_pkg::RATE_W;

    logic signed [RW-1:0]          rate;
    logic                          ok;
    logic [fsrl_pkg::MODE_W-1:0]   mode;
    logic [fsrl_pkg::H_W-1:0]      weight;

    assign rate   = $signed(m_axis_tdata[RW-1:0]);
    assign ok     = m_axis_tdata[RW];
    assign mode   = m_axis_tdata[RW+fsrl_pkg::MODE_W:RW+1];
    assign weight = m_axis_tdata[RW+fsrl_pkg::MODE_W+fsrl_pkg::H_W:RW+fsrl_pkg::MODE_W+1];

    // A stalled result holds its transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Input is refused only while a result is held at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input refused without output stall");

    // An undefined rate is reported as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !ok |-> rate == '0)
        else $error("invalid rate not zero");

    // Obstacle mode carries the obstacle weight and no rate.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && mode == fsrl_pkg::MODE_OBSTACLE
        |-> !ok && weight == fsrl_pkg::H_W'(fsrl_pkg::H_OBSTACLE))
        else $error("obstacle result inconsistent");

    // The turn rate stays within the limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> rate <= RW'(fsrl_pkg::RATE_LIMIT)
                       && rate >= -RW'(fsrl_pkg::RATE_LIMIT))
        else $error("turn rate beyond limit");

endmodule

bind free_space_turn_rate_law_core fsrl_checker u_fsrl_checker (.*);
